/* hw/rtl/ytc_pkg.sv */
// ----------------------------------------------------------------------------
// ytc_pkg: shared types and helpers for the Young tableau counter
// Holds the row and count widths, the sequencer states and the small
// combinational helpers that act on a five-row sub-shape.
// ----------------------------------------------------------------------------
package ytc_pkg;

  localparam int ROWS     = 5;
  localparam int LEN_W    = 5;
  localparam int ROWCNT_W = 3;
  // With at most 30 cells in five rows the product of (length + 1) stays
  // at or below 7^5 = 16807, so 15 bits hold any table size or index.
  localparam int SIZE_W   = 15;
  localparam int TOTAL_W  = 8;
  localparam int COUNT_W  = 64;
  localparam int IN_W     = 32;

  localparam int TABLE_DEPTH_DEF = 32768;
  localparam int MAX_CELLS_DEF   = 30;
  localparam int MAX_ROWS_DEF    = 5;

  typedef logic [LEN_W-1:0]   len_t;
  typedef len_t [ROWS-1:0]    lens_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef size_t [ROWS-1:0]   strides_t;
  typedef logic [ROWS-1:0]    row_mask_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SIZE,
    S_SEED,
    S_WALK,
    S_GATHER,
    S_FETCH,
    S_LOAD,
    S_DONE
  } state_t;

  // Rows must be non-increasing from the back row to the front row.
  function automatic logic shape_ok(input lens_t v);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < ROWS - 1; i++) begin
      if (v[i] < v[i+1]) ok = 1'b0;
    end
    return ok;
  endfunction

  // Rows whose last cell can be removed while keeping a valid shape.
  function automatic row_mask_t corner_mask(input lens_t v);
    row_mask_t m;
    for (int i = 0; i < ROWS; i++) begin
      if (i == ROWS - 1) m[i] = (v[i] != '0);
      else               m[i] = (v[i] != '0) && (v[i] > v[i+1]);
    end
    return m;
  endfunction

  // Mixed-radix increment with the front row running fastest.
  function automatic lens_t fill_advance(input lens_t fill, input lens_t lim);
    lens_t r;
    logic  carry;
    r     = fill;
    carry = 1'b1;
    for (int j = ROWS - 1; j > 0; j--) begin
      if (carry) begin
        if (fill[j] >= lim[j]) begin
          r[j] = '0;
        end else begin
          r[j]  = LEN_W'(fill[j] + 1'b1);
          carry = 1'b0;
        end
      end
    end
    if (carry) r[0] = LEN_W'(fill[0] + 1'b1);
    return r;
  endfunction

endpackage

/* hw/rtl/ytc_table.sv */
// ----------------------------------------------------------------------------
// ytc_table: count table storage
// Single-port-write, single-port-read synchronous RAM with registered
// read data.
// ----------------------------------------------------------------------------
module ytc_table #(
  parameter int DEPTH  = ytc_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_W = $clog2(ytc_pkg::TABLE_DEPTH_DEF)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  ytc_pkg::count_t      wr_data,
  input  logic [ADDR_W-1:0]    rd_addr,
  output ytc_pkg::count_t      rd_data
);

  ytc_pkg::count_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/young_tableau_counter_top.sv */
// ----------------------------------------------------------------------------
// young_tableau_counter_top: standard Young tableau counter
// Counts the standard Young tableaux of a shape of up to five rows by a
// dynamic-programming walk over all sub-shapes, kept in one count table.
// ----------------------------------------------------------------------------
// The walk covers all N sub-shapes, N being the product of (row length + 1),
// and makes one table read per removable corner of each valid one. A shape
// rejected for its cells or row order skips the walk. Throughput: one
// request at a time; the next is taken while the result waits in the output
// register. Synchronous reset clears the sequencer and output valid only;
// the count table is never cleared.
module young_tableau_counter_top #(
  parameter int TABLE_DEPTH = ytc_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_CELLS   = ytc_pkg::MAX_CELLS_DEF,
  parameter int MAX_ROWS    = ytc_pkg::MAX_ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // Fields from bit 0 up: row_count[2:0], row_len0[7:3], row_len1[12:8],
  // row_len2[17:13], row_len3[22:18], row_len4[27:23], zero fill.
  input  logic [ytc_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // Fields from bit 0 up: tableau_count[63:0].
  output ytc_pkg::count_t             m_axis_tdata
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int ROWS   = ytc_pkg::ROWS;
  localparam int LEN_W  = ytc_pkg::LEN_W;
  localparam int SIZE_W = ytc_pkg::SIZE_W;

  // Sequencer and control state.
  ytc_pkg::state_t state, state_next;
  logic            rd_pend, rd_pend_next;
  logic            out_valid, out_valid_next;

  // Per-request working registers.
  ytc_pkg::lens_t     len, len_next;
  ytc_pkg::strides_t  stride, stride_next;
  ytc_pkg::size_t     size, size_next;
  logic [2:0]         k, k_next;
  ytc_pkg::size_t     idx, idx_next;
  ytc_pkg::lens_t     fill, fill_next;
  ytc_pkg::row_mask_t corners, corners_next;
  ytc_pkg::count_t    sum, sum_next;
  ytc_pkg::count_t    result, result_next;
  ytc_pkg::count_t    out_data, out_data_next;

  // Count table port.
  logic            wr_en;
  logic [ADDR_W-1:0] wr_addr;
  ytc_pkg::count_t wr_data;
  logic [ADDR_W-1:0] rd_addr;
  ytc_pkg::count_t rd_data;

  // Table indexes never reach the table depth, so widening or narrowing
  // the index to the address width loses nothing.
  function automatic logic [ADDR_W-1:0] to_addr(input ytc_pkg::size_t v);
    logic [SIZE_W+ADDR_W-1:0] wide;
    wide = {{ADDR_W{1'b0}}, v};
    return wide[ADDR_W-1:0];
  endfunction

  ytc_table #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ytc_pkg::S_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rd_pend   <= rd_pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    len      <= len_next;
    stride   <= stride_next;
    size     <= size_next;
    k        <= k_next;
    idx      <= idx_next;
    fill     <= fill_next;
    corners  <= corners_next;
    sum      <= sum_next;
    result   <= result_next;
    out_data <= out_data_next;
  end

  always_comb begin
    logic [ytc_pkg::ROWCNT_W-1:0]  rows;
    logic [ytc_pkg::TOTAL_W-1:0]   total;
    logic [SIZE_W+LEN_W:0]         prod;
    ytc_pkg::count_t               sum_acc;
    logic [2:0]                    sel;
    ytc_pkg::size_t                last;

    state_next     = state;
    rd_pend_next   = 1'b0;
    out_valid_next = out_valid && !m_axis_tready;
    len_next       = len;
    stride_next    = stride;
    size_next      = size;
    k_next         = k;
    idx_next       = idx;
    fill_next      = fill;
    corners_next   = corners;
    sum_next       = sum;
    result_next    = result;
    out_data_next  = out_data;

    wr_en   = 1'b0;
    wr_addr = to_addr(idx);
    wr_data = sum;
    rd_addr = to_addr(idx);
    s_axis_tready = 1'b0;

    rows    = s_axis_tdata[ytc_pkg::ROWCNT_W-1:0];
    total   = '0;
    prod    = '0;
    sum_acc = rd_pend ? sum + rd_data : sum;
    sel     = '0;
    last    = SIZE_W'(size - 1'b1);

    unique case (state)
      ytc_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (32'(rows) > MAX_ROWS) rows = ytc_pkg::ROWCNT_W'(MAX_ROWS);
        if (s_axis_tvalid) begin
          // Rows at or beyond the row count hold no cells.
          for (int i = 0; i < ROWS; i++) begin
            len_next[i] = (ytc_pkg::ROWCNT_W'(i) < rows) ?
                          s_axis_tdata[ytc_pkg::ROWCNT_W + i*LEN_W +: LEN_W] : '0;
          end
          state_next = ytc_pkg::S_CHECK;
        end
      end

      ytc_pkg::S_CHECK: begin
        for (int i = 0; i < ROWS; i++) begin
          total = ytc_pkg::TOTAL_W'(total + ytc_pkg::TOTAL_W'(len[i]));
        end
        if (32'(total) > MAX_CELLS || !ytc_pkg::shape_ok(len)) begin
          result_next = '0;
          state_next  = ytc_pkg::S_DONE;
        end else begin
          size_next  = SIZE_W'(1);
          k_next     = 3'(ROWS - 1);
          state_next = ytc_pkg::S_SIZE;
        end
      end

      // Strides from the front row back, one multiply per cycle.
      ytc_pkg::S_SIZE: begin
        stride_next[k] = size;
        prod = size * (LEN_W + 1)'({1'b0, len[k]} + 1'b1);
        size_next = prod[SIZE_W-1:0];
        if (k == 3'd0) begin
          state_next = ytc_pkg::S_SEED;
        end else begin
          k_next = 3'(k - 1'b1);
        end
      end

      ytc_pkg::S_SEED: begin
        if (32'(size) > TABLE_DEPTH) begin
          result_next = '0;
          state_next  = ytc_pkg::S_DONE;
        end else begin
          // The empty shape has exactly one tableau.
          wr_en   = 1'b1;
          wr_addr = to_addr('0);
          wr_data = ytc_pkg::COUNT_W'(1);
          if (size == SIZE_W'(1)) begin
            idx_next   = '0;
            state_next = ytc_pkg::S_FETCH;
          end else begin
            idx_next   = SIZE_W'(1);
            fill_next  = ytc_pkg::fill_advance('0, len);
            state_next = ytc_pkg::S_WALK;
          end
        end
      end

      // Skip sub-shapes whose rows are out of order at one per cycle.
      ytc_pkg::S_WALK: begin
        if (ytc_pkg::shape_ok(fill)) begin
          corners_next = ytc_pkg::corner_mask(fill);
          sum_next     = '0;
          state_next   = ytc_pkg::S_GATHER;
        end else if (idx == last) begin
          state_next = ytc_pkg::S_FETCH;
        end else begin
          idx_next  = SIZE_W'(idx + 1'b1);
          fill_next = ytc_pkg::fill_advance(fill, len);
        end
      end

      // One corner read per cycle; each read returns in the next cycle and is
      // added to the sum as it returns. The sum is written once all have landed, so
      // a later read of this entry always sees the new value.
      ytc_pkg::S_GATHER: begin
        sum_next = sum_acc;
        if (corners != '0) begin
          for (int i = ROWS - 1; i >= 0; i--) begin
            if (corners[i]) sel = 3'(i);
          end
          rd_addr      = to_addr(SIZE_W'(idx - stride[sel]));
          corners_next = corners & ~(ytc_pkg::row_mask_t'(1) << sel);
          rd_pend_next = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_addr = to_addr(idx);
          wr_data = sum_acc;
          if (idx == last) begin
            state_next = ytc_pkg::S_FETCH;
          end else begin
            idx_next   = SIZE_W'(idx + 1'b1);
            fill_next  = ytc_pkg::fill_advance(fill, len);
            state_next = ytc_pkg::S_WALK;
          end
        end
      end

      ytc_pkg::S_FETCH: begin
        rd_addr    = to_addr(last);
        state_next = ytc_pkg::S_LOAD;
      end

      ytc_pkg::S_LOAD: begin
        result_next = rd_data;
        state_next  = ytc_pkg::S_DONE;
      end

      ytc_pkg::S_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = result;
          state_next     = ytc_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ytc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/ytc_checker.sv */
// ----------------------------------------------------------------------------
// ytc_checker: port-level checks for the Young tableau counter
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module ytc_checker (
  input logic            clk,
  input logic            rst,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input ytc_pkg::count_t m_axis_tdata
);

  // A pending result is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // The block works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in progress");

  // A result never appears in the cycle right after a request is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result appeared too early after a request");

  // A new result is loaded as the block finishes, so it shows up together
  // with the block being ready for the next request.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result loaded without returning to idle");

endmodule

bind young_tableau_counter_top ytc_checker u_ytc_checker (.*);
